/* hdl/cvsr_pkg.sv */
// cvsr_pkg: shared widths, reset values, register indexes and transaction types
// for the step recorder. No dependencies; used by every module under hdl.
package cvsr_pkg;

	localparam int ADC_W        = 12;
	localparam int STEP_OUT_W   = 4;
	localparam int DEB_W        = 8;
	localparam int BLINK_W      = 10;
	localparam int LEVELS_W     = 4;
	localparam int IN_DATA_W    = 16;
	localparam int OUT_DATA_W   = 32;

	localparam int DEF_STEPS       = 16;
	localparam int DEF_SAMPLE_BITS = 12;

	localparam logic [DEB_W-1:0]   DEB_RESET   = 8'd20;
	localparam logic [BLINK_W-1:0] BLINK_RESET = 10'd250;

	// configuration register map
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 10;
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLINK_TICKS    = 1'd1;

	typedef struct packed {
		logic                  en;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
	} cvsr_cfg_wr_t;

	// classified tick, front to back
	typedef struct packed {
		logic             trig;
		logic             mode;
		logic [ADC_W-1:0] sample;
	} cvsr_evt_t;

	// result transaction, step_event in bit 0
	typedef struct packed {
		logic                  led_on;
		logic                  recording_mode;
		logic [ADC_W-1:0]      served_value;
		logic [STEP_OUT_W-1:0] served_step;
		logic [ADC_W-1:0]      dac_value;
		logic                  dac_write;
		logic                  step_event;
	} cvsr_res_t;

endpackage

/* hdl/cvsr_front.sv */
// cvsr_front: edge detection and button debounce; turns each input transaction
// into a trigger/mode event. Depends on cvsr_pkg.
module cvsr_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cvsr_pkg::cvsr_cfg_wr_t     cfg_wr,
	input  logic                       push,
	input  logic [cvsr_pkg::IN_DATA_W-1:0] in_data,
	output cvsr_pkg::cvsr_evt_t        evt
);

	logic [cvsr_pkg::LEVELS_W-1:0] lvl;
	logic [cvsr_pkg::LEVELS_W-1:0] prev_q;
	logic [cvsr_pkg::LEVELS_W-1:0] rise;
	logic [cvsr_pkg::DEB_W-1:0]    deb_q;
	logic [cvsr_pkg::DEB_W-1:0]    deb_eff;
	logic [cvsr_pkg::DEB_W-1:0]    tw_q, tw_d;
	logic [cvsr_pkg::DEB_W-1:0]    mw_q, mw_d;
	logic                          t_act, m_act;

	// bit 0 trig button, 1 mode button, 2 trig pulse, 3 mode pulse
	assign lvl     = in_data[cvsr_pkg::LEVELS_W-1:0];
	assign rise    = lvl & ~prev_q;
	assign deb_eff = (deb_q == '0) ? cvsr_pkg::DEB_W'(1) : deb_q;

	always_comb begin
		tw_d  = tw_q;
		t_act = 1'b0;
		if (tw_q != '0) begin
			tw_d  = tw_q - cvsr_pkg::DEB_W'(1);
			t_act = (tw_d == '0) && lvl[0];
		end else if (rise[0]) begin
			tw_d = deb_eff;
		end
	end

	always_comb begin
		mw_d  = mw_q;
		m_act = 1'b0;
		if (mw_q != '0) begin
			mw_d  = mw_q - cvsr_pkg::DEB_W'(1);
			m_act = (mw_d == '0) && lvl[1];
		end else if (rise[1]) begin
			mw_d = deb_eff;
		end
	end

	assign evt.trig   = t_act || rise[2];
	assign evt.mode   = m_act || rise[3];
	assign evt.sample = in_data[cvsr_pkg::IN_DATA_W-1:cvsr_pkg::LEVELS_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			tw_q   <= '0;
			mw_q   <= '0;
			deb_q  <= cvsr_pkg::DEB_RESET;
		end else begin
			if (cfg_wr.en && cfg_wr.idx == cvsr_pkg::CFG_DEBOUNCE_TICKS) begin
				deb_q <= cfg_wr.data[cvsr_pkg::DEB_W-1:0];
			end
			if (push) begin
				prev_q <= lvl;
				tw_q   <= tw_d;
				mw_q   <= mw_d;
			end
		end
	end

	// a running wait counts down by exactly one per transaction
	a_wait_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(push && tw_q != '0) |=> (tw_q == $past(tw_q) - cvsr_pkg::DEB_W'(1)))
		else $error("trigger debounce wait did not count down");

endmodule

/* hdl/cvsr_fifo.sv */
// cvsr_fifo: two-entry event queue between front and back.
// Depends on cvsr_pkg for the event type.
module cvsr_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  cvsr_pkg::cvsr_evt_t push_evt,
	input  logic                pop,
	output cvsr_pkg::cvsr_evt_t head,
	output logic                full,
	output logic                empty
);

	localparam int DEPTH = 2;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int PTR_W = $clog2(DEPTH);

	cvsr_pkg::cvsr_evt_t ent_q [DEPTH];
	logic [PTR_W-1:0]    wr_q, rd_q;
	logic [CNT_W-1:0]    cnt_q;

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_evt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("event queue popped while empty");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("event queue pushed while full");

endmodule

/* hdl/cvsr_back.sv */
// cvsr_back: step store, pointer, mode and LED blink; executes queued events
// and holds the result register. Depends on cvsr_pkg.
module cvsr_back #(
	parameter int STEPS       = cvsr_pkg::DEF_STEPS,
	parameter int SAMPLE_BITS = cvsr_pkg::DEF_SAMPLE_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cvsr_pkg::cvsr_cfg_wr_t cfg_wr,
	input  logic                   q_empty,
	input  cvsr_pkg::cvsr_evt_t    head,
	output logic                   pop,
	output logic                   res_valid,
	input  logic                   res_ready,
	output cvsr_pkg::cvsr_res_t    res
);

	localparam int PTR_W = $clog2(STEPS);

	logic [SAMPLE_BITS-1:0]  mem_q [STEPS];
	logic [STEPS-1:0]        vld_q;
	logic [PTR_W-1:0]        ptr_q, ptr_nxt;
	logic [SAMPLE_BITS-1:0]  rd_q;
	logic                    rd_vld_q;
	logic [SAMPLE_BITS-1:0]  stored;
	logic [SAMPLE_BITS-1:0]  samp;
	logic [SAMPLE_BITS-1:0]  served;
	logic [cvsr_pkg::ADC_W+SAMPLE_BITS-1:0]   samp_ext;
	logic [cvsr_pkg::ADC_W+SAMPLE_BITS-1:0]   served_ext;
	logic [cvsr_pkg::STEP_OUT_W+PTR_W-1:0]    ptr_ext;

	logic                         rec_q, rec_d;
	logic                         led_q, led_d;
	logic [cvsr_pkg::BLINK_W-1:0] blink_q;
	logic [cvsr_pkg::BLINK_W-1:0] cnt_q, cnt_d;
	logic [cvsr_pkg::BLINK_W-1:0] reload;
	logic                         out_vld_q;
	cvsr_pkg::cvsr_res_t          out_q, res_d;

	assign pop       = !q_empty && (!out_vld_q || res_ready);
	assign res_valid = out_vld_q;
	assign res       = out_q;

	// rd_q always holds the entry at ptr_q, prefetched when the pointer moves
	assign stored   = rd_vld_q ? rd_q : '0;
	assign samp_ext = {{SAMPLE_BITS{1'b0}}, head.sample};
	assign samp     = samp_ext[SAMPLE_BITS-1:0];
	assign served   = rec_q ? samp : stored;
	assign served_ext = {{cvsr_pkg::ADC_W{1'b0}}, served};
	assign ptr_ext  = {{cvsr_pkg::STEP_OUT_W{1'b0}}, ptr_q};
	assign ptr_nxt  = (ptr_q == PTR_W'(STEPS - 1)) ? '0 : ptr_q + PTR_W'(1);
	assign reload   = (blink_q == '0) ? cvsr_pkg::BLINK_W'(1) : blink_q;

	always_comb begin
		rec_d = rec_q;
		led_d = led_q;
		cnt_d = cnt_q;
		if (head.mode) begin
			rec_d = !rec_q;
			led_d = 1'b1;
			cnt_d = reload;
		end else if (rec_q) begin
			if (cnt_q <= cvsr_pkg::BLINK_W'(1)) begin
				led_d = !led_q;
				cnt_d = reload;
			end else begin
				cnt_d = cnt_q - cvsr_pkg::BLINK_W'(1);
			end
		end
	end

	always_comb begin
		res_d                = '0;
		res_d.recording_mode = rec_d;
		res_d.led_on         = led_d;
		if (head.trig) begin
			res_d.step_event   = 1'b1;
			res_d.served_step  = ptr_ext[cvsr_pkg::STEP_OUT_W-1:0];
			res_d.served_value = served_ext[cvsr_pkg::ADC_W-1:0];
			if (!rec_q) begin
				res_d.dac_write = 1'b1;
				res_d.dac_value = served_ext[cvsr_pkg::ADC_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.trig) begin
			if (rec_q) begin
				mem_q[ptr_q] <= samp;
			end
			rd_q <= mem_q[ptr_nxt];
		end
		if (pop) begin
			out_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			ptr_q     <= '0;
			rd_vld_q  <= 1'b0;
			rec_q     <= 1'b1;
			led_q     <= 1'b1;
			cnt_q     <= cvsr_pkg::BLINK_RESET;
			blink_q   <= cvsr_pkg::BLINK_RESET;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_wr.en && cfg_wr.idx == cvsr_pkg::CFG_BLINK_TICKS) begin
				blink_q <= cfg_wr.data[cvsr_pkg::BLINK_W-1:0];
			end
			if (pop) begin
				rec_q     <= rec_d;
				led_q     <= led_d;
				cnt_q     <= cnt_d;
				out_vld_q <= 1'b1;
				if (head.trig) begin
					if (rec_q) begin
						vld_q[ptr_q] <= 1'b1;
					end
					rd_vld_q <= vld_q[ptr_nxt];
					ptr_q    <= ptr_nxt;
				end
			end else if (res_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	a_ptr_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head.trig) |=> (ptr_q == (($past(ptr_q) == PTR_W'(STEPS - 1)) ?
			PTR_W'(0) : $past(ptr_q) + PTR_W'(1))))
		else $error("step pointer did not advance modulo the step count");

	a_mode_led: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head.mode) |=> (led_q && rec_q != $past(rec_q)))
		else $error("mode event did not toggle mode and light the LED");

endmodule

/* hdl/cv_step_recorder.sv */
// cv_step_recorder: top level; wires front, event queue and back together.
// Depends on cvsr_pkg, cvsr_front, cvsr_fifo and cvsr_back.
//
// Takes one transaction per clock cycle while the event queue is not full and
// returns one result per transaction in order. An accepted transaction is queued,
// then executed into the result register, held until taken. The front (edge
// detect, debounce) and the back (step store, mode, LED blink, result register)
// run independently through a two-entry queue, so the input keeps accepting up
// to two transactions while a finished result waits. The step store is held
// as zero after reset through per-entry valid bits; there is no clearing pass.
module cv_step_recorder #(
	parameter int STEPS       = cvsr_pkg::DEF_STEPS,
	parameter int SAMPLE_BITS = cvsr_pkg::DEF_SAMPLE_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [0] trig_button_level, [1] mode_button_level, [2] trig_pulse_level,
	// [3] mode_pulse_level, [15:4] adc_sample
	input  logic [cvsr_pkg::IN_DATA_W-1:0]  s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [0] step_event, [1] dac_write, [13:2] dac_value, [17:14] served_step,
	// [29:18] served_value, [30] recording_mode, [31] led_on
	output logic [cvsr_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [cvsr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cvsr_pkg::CFG_DATA_W-1:0] cfg_data
);

	cvsr_pkg::cvsr_cfg_wr_t cfg_wr;
	cvsr_pkg::cvsr_evt_t    evt, head;
	cvsr_pkg::cvsr_res_t    res;
	logic                   push, pop, q_full, q_empty;

	assign cfg_ready   = 1'b1;
	assign cfg_wr.en   = cfg_valid;
	assign cfg_wr.idx  = cfg_index;
	assign cfg_wr.data = cfg_data;

	assign s_tready = !q_full;
	assign push     = s_tvalid && !q_full;
	assign m_tdata  = res;

	cvsr_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_wr  (cfg_wr),
		.push    (push),
		.in_data (s_tdata),
		.evt     (evt)
	);

	cvsr_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_evt (evt),
		.pop      (pop),
		.head     (head),
		.full     (q_full),
		.empty    (q_empty)
	);

	cvsr_back #(
		.STEPS       (STEPS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_wr),
		.q_empty   (q_empty),
		.head      (head),
		.pop       (pop),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

endmodule

/* dv/cvsr_tb_pkg.sv */
// cvsr_tb_pkg: result predictor and scoreboard for the step recorder testbench.
// Depends on cvsr_pkg for widths, reset values, register indexes and the result layout.
package cvsr_tb_pkg;

	class step_scoreboard;
		logic [cvsr_pkg::DEB_W-1:0]   debounce;
		logic [cvsr_pkg::BLINK_W-1:0] blink;
		logic [3:0]                   prev_lv;
		logic [cvsr_pkg::DEB_W-1:0]   trig_wait;
		logic [cvsr_pkg::DEB_W-1:0]   mode_wait;
		logic [cvsr_pkg::ADC_W-1:0]   steps [cvsr_pkg::DEF_STEPS];
		logic [3:0]                   step_ptr;
		logic                         recording;
		logic                         led;
		logic [cvsr_pkg::BLINK_W-1:0] blink_left;
		cvsr_pkg::cvsr_res_t          tick_results [$];
		int                           errors;
		int                           n_results;

		function new();
			debounce   = cvsr_pkg::DEB_RESET;
			blink      = cvsr_pkg::BLINK_RESET;
			prev_lv    = '0;
			trig_wait  = '0;
			mode_wait  = '0;
			foreach (steps[i])
				steps[i] = '0;
			step_ptr   = '0;
			recording  = 1'b1;
			led        = 1'b1;
			blink_left = cvsr_pkg::BLINK_RESET;
			errors     = 0;
			n_results  = 0;
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		function int pending();
			return tick_results.size();
		endfunction

		function void set_reg(logic [cvsr_pkg::CFG_IDX_W-1:0] idx,
				logic [cvsr_pkg::CFG_DATA_W-1:0] data);
			case (idx)
				cvsr_pkg::CFG_DEBOUNCE_TICKS: debounce = data[cvsr_pkg::DEB_W-1:0];
				cvsr_pkg::CFG_BLINK_TICKS:    blink    = data[cvsr_pkg::BLINK_W-1:0];
				default: ;
			endcase
		endfunction

		// one button's debounce: returns 1 when the button acts in this tick
		function logic button_step(inout logic [cvsr_pkg::DEB_W-1:0] wait_left,
				input logic level, input logic rose);
			if (wait_left != '0) begin
				wait_left--;
				return (wait_left == '0) && level;
			end
			if (rose)
				wait_left = (debounce == '0) ? cvsr_pkg::DEB_W'(1) : debounce;
			return 1'b0;
		endfunction

		function void take_tick(logic [cvsr_pkg::IN_DATA_W-1:0] d);
			logic [3:0]                   lv;
			logic [3:0]                   rises;
			logic [cvsr_pkg::ADC_W-1:0]   smp;
			logic                         trig;
			logic                         mode;
			logic [cvsr_pkg::BLINK_W-1:0] reload;
			cvsr_pkg::cvsr_res_t          r;
			lv     = d[3:0];
			smp    = d[4 +: cvsr_pkg::ADC_W];
			rises  = lv & ~prev_lv;
			trig   = button_step(trig_wait, lv[0], rises[0]);
			mode   = button_step(mode_wait, lv[1], rises[1]);
			trig   = trig | rises[2];
			mode   = mode | rises[3];
			prev_lv = lv;
			reload = (blink == '0) ? cvsr_pkg::BLINK_W'(1) : blink;
			r = '0;
			if (trig) begin
				r.step_event  = 1'b1;
				r.served_step = step_ptr;
				if (recording) begin
					steps[step_ptr] = smp;
					r.served_value  = smp;
				end else begin
					r.dac_write    = 1'b1;
					r.dac_value    = steps[step_ptr];
					r.served_value = steps[step_ptr];
				end
				step_ptr++;
			end
			// trigger above saw the old mode
			if (mode) begin
				recording  = ~recording;
				led        = 1'b1;
				blink_left = reload;
			end else if (recording) begin
				if (blink_left <= cvsr_pkg::BLINK_W'(1)) begin
					led        = ~led;
					blink_left = reload;
				end else begin
					blink_left--;
				end
			end
			r.recording_mode = recording;
			r.led_on         = led;
			tick_results.push_back(r);
		endfunction

		task cmp(string field, logic [15:0] e, logic [15:0] g);
			if (e !== g)
				report($sformatf("result %0d %s: expected %0h got %0h", n_results, field, e, g));
		endtask

		task check_result(logic [cvsr_pkg::OUT_DATA_W-1:0] d);
			cvsr_pkg::cvsr_res_t got;
			cvsr_pkg::cvsr_res_t exp_r;
			got = d;
			if (tick_results.size() == 0) begin
				report($sformatf("result %0d arrived with nothing outstanding", n_results));
				n_results++;
				return;
			end
			exp_r = tick_results.pop_front();
			cmp("step_event", 16'(exp_r.step_event), 16'(got.step_event));
			cmp("dac_write", 16'(exp_r.dac_write), 16'(got.dac_write));
			cmp("dac_value", 16'(exp_r.dac_value), 16'(got.dac_value));
			cmp("served_step", 16'(exp_r.served_step), 16'(got.served_step));
			cmp("served_value", 16'(exp_r.served_value), 16'(got.served_value));
			cmp("recording_mode", 16'(exp_r.recording_mode), 16'(got.recording_mode));
			cmp("led_on", 16'(exp_r.led_on), 16'(got.led_on));
			n_results++;
		endtask

		task finish();
			if (tick_results.size() != 0)
				report($sformatf("%0d results never arrived", tick_results.size()));
		endtask
	endclass

endpackage

/* dv/tb.sv */
// tb: top level of the step recorder testbench; drives ticks and register writes,
// stalls the output side and checks every result. Depends on cvsr_pkg and cvsr_tb_pkg.
module tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [3:0] TRIG_BTN   = 4'b0001;
	localparam logic [3:0] MODE_BTN   = 4'b0010;
	localparam logic [3:0] TRIG_PULSE = 4'b0100;
	localparam logic [3:0] MODE_PULSE = 4'b1000;
	localparam int HOLDOFF_CYCLES = 80;

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            s_tvalid  = 1'b0;
	logic                            s_tready;
	logic [cvsr_pkg::IN_DATA_W-1:0]  s_tdata   = '0;
	logic                            m_tvalid;
	logic                            m_tready  = 1'b0;
	logic [cvsr_pkg::OUT_DATA_W-1:0] m_tdata;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [cvsr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [cvsr_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

	cvsr_tb_pkg::step_scoreboard sb;
	logic calm     = 1'b0;
	logic hold_req = 1'b0;
	int   burst_left;
	int   cur_debounce;
	logic [3:0] lv_now;
	int   lv_hold [4];

	cv_step_recorder DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.set_reg(cfg_index, cfg_data);
			if (s_tvalid && s_tready)
				sb.take_tick(s_tdata);
			if (m_tvalid && m_tready)
				sb.check_result(m_tdata);
		end
	end

	// output side: random stall patterns, a long hold-off on request
	initial begin
		int hold_left;
		int pos;
		logic [31:0] pattern;
		hold_left = 0;
		pos = 0;
		pattern = '1;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req <= 1'b0;
				hold_left = HOLDOFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (calm) begin
				m_tready <= 1'b1;
			end else begin
				if (pos == 0) begin
					case ($urandom_range(0, 3))
						0: pattern = '1;
						1: pattern = $urandom;
						2: pattern = $urandom | $urandom;
						default: pattern = $urandom & $urandom;
					endcase
				end
				m_tready <= pattern[pos];
				pos = (pos + 1) % 32;
			end
		end
	end

	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	function automatic logic [cvsr_pkg::ADC_W-1:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return cvsr_pkg::ADC_W'($urandom);
		endcase
	endfunction

	// button presses and releases around the debounce time, short pulses, some noise
	function automatic logic [3:0] next_levels();
		logic [3:0] lv;
		int lo;
		lo = (cur_debounce > 1) ? cur_debounce - 1 : 1;
		for (int i = 0; i < 4; i++) begin
			if (lv_hold[i] == 0) begin
				lv_now[i] = ~lv_now[i];
				if (i < 2)
					lv_hold[i] = $urandom_range(0, 1) ? $urandom_range(1, 3) :
						(lv_now[i] ? $urandom_range(lo, cur_debounce + 3) :
						$urandom_range(1, cur_debounce));
				else
					lv_hold[i] = lv_now[i] ? $urandom_range(1, 3) : $urandom_range(1, 8);
			end
			lv_hold[i]--;
		end
		lv = lv_now;
		if ($urandom_range(0, 9) == 0)
			lv = 4'($urandom);
		return lv;
	endfunction

	task automatic send_tick(input logic [3:0] lv, input logic [cvsr_pkg::ADC_W-1:0] smp);
		int gap;
		if (burst_left == 0) begin
			burst_left = calm ? 1000 : $urandom_range(1, 12);
			gap = (calm || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= {smp, lv};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	task automatic run_random(input int n);
		repeat (n) send_tick(next_levels(), pick_sample());
	endtask

	// sender pauses until every outstanding result is back
	task automatic drain();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (sb.pending() > 0) @(negedge clk);
	endtask

	task automatic configure(input logic [cvsr_pkg::CFG_DATA_W-1:0] deb,
			input logic [cvsr_pkg::CFG_DATA_W-1:0] blk);
		cfg_valid <= 1'b1;
		cfg_index <= cvsr_pkg::CFG_DEBOUNCE_TICKS;
		cfg_data  <= deb;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_index <= cvsr_pkg::CFG_BLINK_TICKS;
		cfg_data  <= blk;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		cur_debounce = (deb[cvsr_pkg::DEB_W-1:0] == '0) ? 1 :
			int'(deb[cvsr_pkg::DEB_W-1:0]);
	endtask

	initial begin
		sb = new();
		cur_debounce = int'(cvsr_pkg::DEB_RESET);
		lv_now = '0;
		burst_left = 0;
		foreach (lv_hold[i])
			lv_hold[i] = 0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// pulse inputs at reset settings: record, play, trigger with mode in one tick
		send_tick('0, '0);
		send_tick(TRIG_PULSE, 12'hFFF);
		send_tick('0, '0);
		send_tick(TRIG_PULSE, 12'h000);
		send_tick('0, 12'h123);
		send_tick(MODE_PULSE, 12'h456);
		send_tick('0, '0);
		send_tick(TRIG_PULSE, 12'h789);
		send_tick(TRIG_PULSE | MODE_PULSE, 12'hABC);
		send_tick('0, '0);
		send_tick(TRIG_PULSE, 12'hA5A);
		send_tick('0, 12'hFFF);
		drain();

		// buttons with a short debounce
		configure(10'd2, 10'd3);
		send_tick(TRIG_BTN, 12'h111);
		send_tick(TRIG_BTN, 12'h222);
		send_tick(TRIG_BTN | TRIG_PULSE, 12'h333);  // button and pulse: served once
		send_tick('0, '0);
		send_tick(TRIG_BTN, 12'h444);
		send_tick('0, '0);                          // released during the wait
		send_tick(TRIG_BTN, 12'h555);               // edge during the wait is ignored; wait ends here, no new wait
		send_tick('0, '0);
		send_tick(MODE_BTN | MODE_PULSE, 12'h666);
		send_tick('0, '0);
		send_tick('0, '0);                          // released: no mode event
		send_tick(MODE_BTN, 12'h777);
		send_tick(MODE_BTN, 12'h888);
		send_tick(MODE_BTN | MODE_PULSE, 12'h999);  // single toggle
		send_tick('0, '0);
		run_random(50);
		drain();

		configure(10'd20, 10'd250);
		run_random(50);
		drain();

		configure(10'd0, 10'd0);
		run_random(40);
		drain();

		calm <= 1'b1;
		configure(10'd1, 10'd1);
		run_random(40);
		drain();
		calm <= 1'b0;

		configure(10'h3FF, 10'h3FF);
		run_random(100);
		drain();

		// long output hold-off while ticks keep coming
		configure(10'd5, 10'd7);
		hold_req <= 1'b1;
		run_random(60);
		drain();
		run_random(20);
		drain();

		configure(cvsr_pkg::CFG_DATA_W'($urandom_range(1, 12)),
			cvsr_pkg::CFG_DATA_W'($urandom_range(1, 20)));
		run_random(60);
		drain();

		repeat (8) @(negedge clk);
		sb.finish();
		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

/* sim.f */
hdl/cvsr_pkg.sv
hdl/cvsr_front.sv
hdl/cvsr_fifo.sv
hdl/cvsr_back.sv
hdl/cv_step_recorder.sv
dv/cvsr_tb_pkg.sv
dv/tb.sv
